// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define FPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define FPR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FPR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fpr_pkg.sv =====
package fpr_pkg;

   // Defaults for the top-level parameters
   localparam int DEFAULT_FRAMES    = 4;
   localparam int DEFAULT_PAGE_BITS = 16;

   // Fixed field widths
   localparam int PAGE_W  = 16;
   localparam int SLOT_W  = 2;
   localparam int FAULT_W = 16;
   localparam int CFG_W   = 3;

   // Age counter for FIFO order
   localparam int AGE_W = 3;
   localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
   localparam logic [AGE_W-1:0] AGE_NEW = AGE_W'(1);

   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(3);
   localparam logic REG_FRAMES_IN_USE = 1'b0;

   // Controller to datapath
   typedef struct packed {
      logic load;     // latch the item, clear the scan trackers
      logic step;     // examine one frame, advance the index
      logic commit;   // update frames, drive the result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic match;    // current frame holds the page
      logic last;     // current frame is the last one in use
   } status_type;

endpackage

// ===== hw/rtl/fpr_csr.sv =====
module fpr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fpr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [fpr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [fpr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output logic [fpr_pkg::CFG_W-1:0]           frames_in_use
);

   logic [fpr_pkg::CFG_W-1:0] frames_in_use_ff;
   logic [fpr_pkg::CFG_W-1:0] frames_in_use_in;
   logic                      reg_sel;

   // Word index; byte offset bits are ignored
   assign reg_sel = paddr[2];
   assign pready  = 1'b1;

   // Write decode
   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_sel)
            fpr_pkg::REG_FRAMES_IN_USE: frames_in_use_in = pwdata[fpr_pkg::CFG_W-1:0];
            default: frames_in_use_in = frames_in_use_ff;
         endcase
      end
   end

   // Read decode
   always_comb begin
      unique case (reg_sel)
         fpr_pkg::REG_FRAMES_IN_USE:
            prdata = fpr_pkg::CSR_DATA_W'(frames_in_use_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= fpr_pkg::FRAMES_IN_USE_RESET;
      end else begin
         frames_in_use_ff <= frames_in_use_in;
      end
   end

   assign frames_in_use = frames_in_use_ff;

endmodule

// ===== hw/rtl/fpr_ctrl.sv =====
module fpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fpr_pkg::status_type  status,
   output fpr_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   // Commands follow the state; load follows the accept
   always_comb begin
      cmd.load   = start && !busy_ff;
      cmd.step   = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_UPDATE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_SCAN;
                  busy_ff  <= 1'b1;
               end
            end
            ST_SCAN: begin
               // stop at the first hit or after the last frame in use
               if (status.match || status.last) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

endmodule

// ===== hw/rtl/fpr_dpath.sv =====
module fpr_dpath #(
   parameter int FRAMES    = fpr_pkg::DEFAULT_FRAMES,
   parameter int PAGE_BITS = fpr_pkg::DEFAULT_PAGE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fpr_pkg::cmd_type                  cmd,
   output fpr_pkg::status_type               status,
   input  logic [fpr_pkg::CFG_W-1:0]         frames_in_use,
   input  logic [fpr_pkg::PAGE_W-1:0]        req_page,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [fpr_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                              rsp_evicted_valid,
   output logic [fpr_pkg::PAGE_W-1:0]        rsp_evicted_page,
   output logic [fpr_pkg::FAULT_W-1:0]       rsp_fault_total
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int AGE_W = fpr_pkg::AGE_W;

   // Frame table
   logic [PAGE_BITS-1:0] frame_page_ff [FRAMES];
   logic [PAGE_BITS-1:0] frame_page_in [FRAMES];
   logic [FRAMES-1:0]    frame_valid_ff;
   logic [FRAMES-1:0]    frame_valid_in;
   logic [AGE_W-1:0]     frame_age_ff  [FRAMES];
   logic [AGE_W-1:0]     frame_age_in  [FRAMES];
   logic [fpr_pkg::FAULT_W-1:0] fault_ff;
   logic [fpr_pkg::FAULT_W-1:0] fault_in;

   // Per-item scan state
   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] page_in;
   logic [CNT_W-1:0]     n_ff;
   logic [CNT_W-1:0]     n_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_in;
   logic                 hit_ff;
   logic                 hit_in;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic [IDX_W-1:0]     hit_idx_in;
   logic                 empty_ff;
   logic                 empty_in;
   logic [IDX_W-1:0]     empty_idx_ff;
   logic [IDX_W-1:0]     empty_idx_in;
   logic [AGE_W-1:0]     best_ff;
   logic [AGE_W-1:0]     best_in;
   logic [IDX_W-1:0]     victim_ff;
   logic [IDX_W-1:0]     victim_in;

   // Result registers
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_hit_ff;
   logic                        rsp_hit_in;
   logic [fpr_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic [fpr_pkg::SLOT_W-1:0]  rsp_slot_in;
   logic                        rsp_ev_valid_ff;
   logic                        rsp_ev_valid_in;
   logic [fpr_pkg::PAGE_W-1:0]  rsp_ev_page_ff;
   logic [fpr_pkg::PAGE_W-1:0]  rsp_ev_page_in;
   logic [fpr_pkg::FAULT_W-1:0] rsp_fault_ff;
   logic [fpr_pkg::FAULT_W-1:0] rsp_fault_in;

   // Helpers
   logic [31:0]          page_wide;
   logic [31:0]          ev_wide;
   logic [31:0]          slot_wide;
   logic [IDX_W-1:0]     slot_idx;
   logic [CNT_W-1:0]     n_clamp;
   logic [AGE_W-1:0]     cur_age;
   logic                 cur_match;

   assign page_wide = 32'(req_page);
   assign ev_wide   = 32'(frame_page_ff[victim_ff]);
   assign slot_wide = 32'(slot_idx);
   assign cur_age   = frame_age_ff[idx_ff];
   assign cur_match = frame_valid_ff[idx_ff] && (frame_page_ff[idx_ff] == page_ff);

   assign status.match = cur_match;
   assign status.last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_ff);

   // Frame count clamped to 1..FRAMES
   always_comb begin
      if (frames_in_use == '0) begin
         n_clamp = CNT_W'(1);
      end else if (32'(frames_in_use) > 32'(FRAMES)) begin
         n_clamp = CNT_W'(FRAMES);
      end else begin
         n_clamp = CNT_W'(frames_in_use);
      end
   end

   // Slot index of the result
   always_comb begin
      if (hit_ff) begin
         slot_idx = hit_idx_ff;
      end else if (empty_ff) begin
         slot_idx = empty_idx_ff;
      end else begin
         slot_idx = victim_ff;
      end
   end

   // Next-state logic
   always_comb begin
      frame_page_in  = frame_page_ff;
      frame_valid_in = frame_valid_ff;
      frame_age_in   = frame_age_ff;
      fault_in       = fault_ff;
      page_in        = page_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      empty_in       = empty_ff;
      empty_idx_in   = empty_idx_ff;
      best_in        = best_ff;
      victim_in      = victim_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in = rsp_ev_page_ff;
      rsp_fault_in   = rsp_fault_ff;

      // new item: latch page and frame count
      if (cmd.load) begin
         page_in   = page_wide[PAGE_BITS-1:0];
         n_in      = n_clamp;
         idx_in    = '0;
         hit_in    = 1'b0;
         empty_in  = 1'b0;
         best_in   = '0;
         victim_in = '0;
      end

      // one frame per cycle: hit, first empty, oldest
      if (cmd.step) begin
         if (cur_match) begin
            hit_in     = 1'b1;
            hit_idx_in = idx_ff;
         end
         if (!frame_valid_ff[idx_ff] && !empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = idx_ff;
         end
         if ((idx_ff == '0) || (cur_age > best_ff)) begin
            best_in   = cur_age;
            victim_in = idx_ff;
         end
         idx_in = idx_ff + IDX_W'(1);
      end

      // apply the outcome and load the result registers
      if (cmd.commit) begin
         rsp_valid_in    = 1'b1;
         rsp_hit_in      = hit_ff;
         rsp_slot_in     = slot_wide[fpr_pkg::SLOT_W-1:0];
         rsp_ev_valid_in = 1'b0;
         rsp_ev_page_in  = '0;
         if (!hit_ff) begin
            if (fault_ff != fpr_pkg::FAULT_MAX) begin
               fault_in = fault_ff + fpr_pkg::FAULT_W'(1);
            end
            if (empty_ff) begin
               frame_valid_in[empty_idx_ff] = 1'b1;
               frame_page_in[empty_idx_ff]  = page_ff;
               frame_age_in[empty_idx_ff]   = fpr_pkg::AGE_NEW;
            end else begin
               rsp_ev_valid_in = 1'b1;
               rsp_ev_page_in  = ev_wide[fpr_pkg::PAGE_W-1:0];
               // age every other frame in use, saturating
               for (int i = 0; i < FRAMES; i++) begin
                  if ((CNT_W'(i) < n_ff) && (IDX_W'(i) != victim_ff) &&
                      (frame_age_ff[i] < fpr_pkg::AGE_MAX)) begin
                     frame_age_in[i] = frame_age_ff[i] + AGE_W'(1);
                  end
               end
               frame_page_in[victim_ff] = page_ff;
               frame_age_in[victim_ff]  = fpr_pkg::AGE_NEW;
            end
         end
         rsp_fault_in = fault_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         frame_age_ff   <= '{default: '0};
         fault_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_valid_ff <= frame_valid_in;
         frame_age_ff   <= frame_age_in;
         fault_ff       <= fault_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload and scan registers
   always_ff @(posedge clock) begin
      frame_page_ff   <= frame_page_in;
      page_ff         <= page_in;
      n_ff            <= n_in;
      idx_ff          <= idx_in;
      hit_ff          <= hit_in;
      hit_idx_ff      <= hit_idx_in;
      empty_ff        <= empty_in;
      empty_idx_ff    <= empty_idx_in;
      best_ff         <= best_in;
      victim_ff       <= victim_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_fault_ff    <= rsp_fault_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_fault_ff;

endmodule

// ===== hw/rtl/fifo_page_replacement.sv =====
// Sequence: the accept moves to the scan state, which examines frames in order up to the
// last frame in use, stopping early on a hit; then the update state, then rsp_valid for one cycle.
// A new item is taken only when idle (busy low), not while a scan or update is in progress.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset is synchronous: frames empty, ages and fault total zero, frames_in_use = 3.
`include "assert_macros.svh"

module fifo_page_replacement #(
   parameter int FRAMES    = fpr_pkg::DEFAULT_FRAMES,
   parameter int PAGE_BITS = fpr_pkg::DEFAULT_PAGE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [fpr_pkg::PAGE_W-1:0]        req_page,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [fpr_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                              rsp_evicted_valid,
   output logic [fpr_pkg::PAGE_W-1:0]        rsp_evicted_page,
   output logic [fpr_pkg::FAULT_W-1:0]       rsp_fault_total,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fpr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fpr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fpr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   fpr_pkg::cmd_type           cmd;
   fpr_pkg::status_type        status;
   logic [fpr_pkg::CFG_W-1:0]  frames_in_use;

   // Register port
   fpr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .frames_in_use (frames_in_use)
   );

   // Sequencer
   fpr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Frame table and result path
   fpr_dpath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .frames_in_use     (frames_in_use),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

   // Checks
   `FPR_ASSERT_NXT(a_accept_busy, clock, reset, !reset && start && !busy, busy,
      "accepted item did not raise busy")
   `FPR_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy,
      "result strobe while still busy")
   `FPR_ASSERT_IMP(a_evict_fault, clock, reset, rsp_valid && rsp_evicted_valid, !rsp_hit,
      "eviction reported on a hit")
   `FPR_ASSERT_IMP(a_fault_count, clock, reset, rsp_valid && !rsp_hit,
      rsp_fault_total != '0, "fault reported with zero fault total")
   `FPR_ASSERT(a_no_evict_zero, clock, reset,
      !(rsp_valid && !rsp_evicted_valid && (rsp_evicted_page != '0)),
      "evicted page nonzero without eviction")

endmodule
